@@ rtl/alpha_blend_pixel_write_top_defines.svh @@
// assertion macros for the alpha blend pixel writer
`ifndef ALPHA_BLEND_PIXEL_WRITE_TOP_DEFINES_SVH
`define ALPHA_BLEND_PIXEL_WRITE_TOP_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define ABPW_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define ABPW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/abpw_pkg.sv @@
// shared constants and types of the alpha blend pixel writer
`timescale 1ns / 1ps
package abpw_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int CFG_W   = 9;
  localparam int COORD_W = 16;
  localparam int COLOR_W = 32;
  localparam int INDEX_W = 16;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic               load;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
  } blend_req_t;

endpackage

@@ rtl/abpw_blend.sv @@
// rgba over blend: registered channel products, then exact divide by 255
`timescale 1ns / 1ps
module abpw_blend import abpw_pkg::*; (
  input  logic               clk,
  input  blend_req_t         req,
  output logic [COLOR_W-1:0] pix
);

  logic [15:0]        prod_fg_r [3];
  logic [15:0]        prod_bg_r [3];
  logic [COLOR_W-1:0] fg_r;
  logic [7:0]         chan [3];

  // exact for every n below 65280
  function automatic logic [7:0] div255(input logic [15:0] n);
    logic [16:0] t;
    t = {1'b0, n} + 17'd1 + {9'd0, n[15:8]};
    return t[15:8];
  endfunction

  always_ff @(posedge clk) begin
    if (req.load) begin
      fg_r <= req.fg;
      for (int i = 0; i < 3; i++) begin
        prod_fg_r[i] <= 16'(req.fg[8*i+8 +: 8]) * 16'(req.fg[7:0]);
        prod_bg_r[i] <= 16'(req.bg[8*i+8 +: 8]) * 16'(ALPHA_OPAQUE - req.fg[7:0]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      chan[i] = div255(prod_fg_r[i] + prod_bg_r[i]);
    end
    if (fg_r[7:0] == ALPHA_OPAQUE) begin
      pix = fg_r;
    end else begin
      pix = {chan[2], chan[1], chan[0], ALPHA_OPAQUE};
    end
  end

endmodule

@@ rtl/alpha_blend_pixel_write_top.sv @@
// top level of the alpha blend pixel writer: framebuffer, sequencer and ports
`timescale 1ns / 1ps
// Alpha blend pixel writer.
// Input stream in_*: one word per pixel draw (x, y, rgba color). The block
// keeps a MAX_WIDTH*MAX_HEIGHT framebuffer of rgba words in one synchronous
// single-port-write ram; each word inside the image gets a read-modify-write.
// Output stream out_*: one word per input word, giving the stored index and
// value, or zeros with tuser low when the position lies outside the image.
// Each word passes in turn through the accept, the address multiply, the ram
// read, the registered channel products and the write-back, done one word at
// a time so every read sees the previous write.
// After reset all MAX_WIDTH*MAX_HEIGHT entries (65536 at the defaults) of the
// ram are swept to zero, one entry a cycle; in_tready stays low
// during the sweep. Config writes (cfg_wr_en, cfg_index, cfg_wdata) are
// taken at any time and should be made while idle.
// The result sits in an output register; the next word is accepted while
// it waits, and the write-back stalls until the receiver takes it.
`include "alpha_blend_pixel_write_top_defines.svh"
module alpha_blend_pixel_write_top import abpw_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // pos_x[15:0], pos_y[31:16], draw_color[63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // pixel_index[15:0], pixel_value[47:16]
  output logic        out_tuser,  // written[0]
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_wdata
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [CFG_W-1:0]   width_r, height_r;
  logic [CFG_W-1:0]   w_eff, h_eff;
  logic [ADDR_W-1:0]  clr_cnt_r;
  logic [CFG_W-1:0]   x_r, y_r;
  logic [COLOR_W-1:0] color_r;
  logic               inside_r;
  logic               inside_nxt;
  logic [ADDR_W-1:0]  idx_r;
  logic [ADDR_W-1:0]  idx_full;
  logic [COLOR_W-1:0] rd_data_r;
  logic [COLOR_W-1:0] blend_pix;
  blend_req_t         blend_req;
  logic               out_tvalid_r;
  logic [47:0]        out_tdata_r;
  logic               out_tuser_r;
  logic               in_accept;
  logic               out_free;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [COLOR_W-1:0] mem_wdata;

  logic [COLOR_W-1:0] frame_mem [DEPTH];

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // register values above the store limits saturate
  assign w_eff = ({23'd0, width_r} > 32'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_r;
  assign h_eff = ({23'd0, height_r} > 32'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : height_r;

  assign inside_nxt = !in_tdata[15] && !in_tdata[31] &&
                      (in_tdata[14:0] < 15'(w_eff)) && (in_tdata[30:16] < 15'(h_eff));

  // y < h <= 511 and x < w <= 511 when inside
  assign idx_full = ADDR_W'(19'(w_eff) * 19'(y_r) + 19'(x_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd256;
      height_r <= 9'd256;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == ADDR_W'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_accept) state_nxt = ST_ADDR;
      ST_ADDR:  state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      x_r      <= in_tdata[8:0];
      y_r      <= in_tdata[24:16];
      color_r  <= in_tdata[63:32];
      inside_r <= inside_nxt;
    end
    if (state_r == ST_ADDR) begin
      idx_r <= idx_full;
    end
  end

  // frame ram: one write port, one registered read port
  assign mem_we    = (state_r == ST_CLEAR) || ((state_r == ST_DONE) && out_free && inside_r);
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : idx_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? '0 : blend_pix;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      rd_data_r <= frame_mem[idx_r];
    end
  end

  assign blend_req.load = (state_r == ST_MUL);
  assign blend_req.fg   = color_r;
  assign blend_req.bg   = rd_data_r;

  abpw_blend u_blend (
    .clk (clk),
    .req (blend_req),
    .pix (blend_pix)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_tuser_r <= inside_r;
      if (inside_r) begin
        out_tdata_r <= {blend_pix, INDEX_W'(idx_r)};
      end else begin
        out_tdata_r <= '0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `ABPW_ASSERT_ALWAYS(a_miss_zero, !out_tvalid || out_tuser || (out_tdata == '0), "miss not zero")
  `ABPW_ASSERT_ALWAYS(a_no_accept_clear, !((state_r == ST_CLEAR) && in_tready), "accept in clear")
  `ABPW_ASSERT_ALWAYS(a_we_state, !mem_we || state_r == ST_CLEAR || state_r == ST_DONE, "bad write")
  `ABPW_ASSERT_NEXT(a_accept_seq, in_accept, (state_r == ST_ADDR), "accept did not start access")

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the alpha blend pixel writer top level
`timescale 1ns / 1ps
module tb import abpw_pkg::*; ();

  localparam int IDLE_LIMIT = 262144;
  localparam int STORE_DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

  typedef struct packed {
    logic        written;
    logic [15:0] index;
    logic [31:0] value;
  } pixel_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // pos_x[15:0], pos_y[31:16], draw_color[63:32]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;  // pixel_index[15:0], pixel_value[47:16]
  logic        out_tuser;  // written[0]
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [8:0]  cfg_wdata;

  alpha_blend_pixel_write_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // predictor state
  bit   [31:0] frame_model [STORE_DEPTH];
  logic [8:0]  frame_width_cfg  = 9'd256;
  logic [8:0]  frame_height_cfg = 9'd256;
  pixel_result_t pixel_expect_q [$];

  int errors        = 0;
  int draws_sent    = 0;
  int pixels_stored = 0;
  int blends_done   = 0;
  int sizes_used    = 1;
  int idle_cycles   = 0;
  int stall_left    = 0;
  int out_stall     = 0;
  bit in_no_gap     = 1'b0;
  bit out_no_stall  = 1'b0;
  pixel_result_t got_px;
  pixel_result_t want_px;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_width();
    return (frame_width_cfg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(frame_width_cfg);
  endfunction

  function automatic int eff_height();
    return (frame_height_cfg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(frame_height_cfg);
  endfunction

  function automatic logic [7:0] blend_channel(logic [7:0] fg, logic [7:0] bg, logic [7:0] a);
    int unsigned sum;
    sum = int'(a) * int'(fg) + (255 - int'(a)) * int'(bg);
    return 8'(sum / 255);
  endfunction

  function automatic logic [31:0] blend_over_px(logic [31:0] fg, logic [31:0] bg);
    logic [7:0] a;
    a = fg[7:0];
    if (a == ALPHA_OPAQUE) return fg;
    return {blend_channel(fg[31:24], bg[31:24], a),
            blend_channel(fg[23:16], bg[23:16], a),
            blend_channel(fg[15:8],  bg[15:8],  a),
            ALPHA_OPAQUE};
  endfunction

  // works out the expected result for one accepted word and queues it
  task automatic predict_pixel(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic [31:0] color);
    pixel_result_t r;
    int w;
    int h;
    int idx;
    w = eff_width();
    h = eff_height();
    r = '0;
    if (!(x < 0 || y < 0 || int'(x) >= w || int'(y) >= h)) begin
      idx = w * int'(y) + int'(x);
      if (idx >= STORE_DEPTH) idx = STORE_DEPTH - 1;
      r.written = 1'b1;
      r.index   = idx[15:0];
      r.value   = blend_over_px(color, frame_model[idx]);
      frame_model[idx] = r.value;
      pixels_stored++;
      if (color[7:0] != ALPHA_OPAQUE) blends_done++;
    end
    pixel_expect_q.push_back(r);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch in %s at %0t: expected %h, got %h", field, $realtime, want, got);
    errors++;
  endtask

  task automatic send_pixel(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic [31:0] color);
    int gap;
    gap = in_no_gap ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {color, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    draws_sent++;
    predict_pixel(x, y, color);
  endtask

  // drains the pipeline, then writes both size registers
  task automatic set_frame_size(input int w, input int h);
    in_tvalid <= 1'b0;
    while (pixel_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_wdata <= w[8:0];
    @(posedge clk);
    frame_width_cfg = w[8:0];
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_wdata <= h[8:0];
    @(posedge clk);
    frame_height_cfg = h[8:0];
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    sizes_used++;
  endtask

  task automatic test_directed_edges();
    send_pixel(0, 0, 32'h11223344);        // blend over a cleared pixel
    send_pixel(0, 0, 32'hAABBCCFF);        // opaque replace
    send_pixel(0, 0, 32'h10203080);        // blend over a colored pixel
    send_pixel(0, 0, 32'hFFFFFF00);        // alpha zero keeps background color
    send_pixel(255, 255, 32'hFFFFFFFF);
    send_pixel(255, 255, 32'h00000000);
    send_pixel(255, 0, 32'h12345601);
    send_pixel(0, 255, 32'hFEDCBAFE);
    send_pixel(128, 77, 32'h80808080);
    send_pixel(256, 0, 32'hFFFFFFFF);      // just past right edge
    send_pixel(0, 256, 32'hFFFFFFFF);      // just past bottom edge
    send_pixel(-1, 0, 32'hFFFFFFFF);
    send_pixel(0, -1, 32'hFFFFFFFF);
    send_pixel(-32768, -32768, 32'h5A5A5AFF);
    send_pixel(32767, 32767, 32'hA5A5A5FF);
    send_pixel(32767, -32768, 32'h01020304);
    send_pixel(-32768, 32767, 32'h01020304);
  endtask

  // zero width or height: nothing lands anywhere
  task automatic test_empty_frame();
    set_frame_size(0, 5);
    send_pixel(0, 0, 32'hFFFFFFFF);
    send_pixel(0, 4, 32'h123456FF);
    set_frame_size(9, 0);
    send_pixel(0, 0, 32'hFFFFFFFF);
    send_pixel(8, 0, 32'h12345680);
  endtask

  // register values above the maximum saturate
  task automatic test_oversized_frame();
    set_frame_size(511, 511);
    send_pixel(255, 255, 32'hC0FFEE40);
    send_pixel(256, 255, 32'hFFFFFFFF);
    send_pixel(255, 256, 32'hFFFFFFFF);
    set_frame_size(257, 300);
    send_pixel(255, 255, 32'h00FF00C0);
    send_pixel(256, 0, 32'hFFFFFFFF);
  endtask

  task automatic test_random_draws(input int count, input bit window);
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0] color;
    int w;
    int h;
    int kind;
    for (int i = 0; i < count; i++) begin
      w = eff_width();
      h = eff_height();
      kind = $urandom_range(0, 9);
      if (kind < 7 && w > 0 && h > 0) begin
        // window mode keeps hitting the same pixels so blends stack up
        x = 16'($urandom_range(0, (window && w > 16) ? 15 : w - 1));
        y = 16'($urandom_range(0, (window && h > 16) ? 15 : h - 1));
      end else if (kind < 9) begin
        x = 16'($urandom_range(0, 255));
        y = 16'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
          0: x = 16'(w);
          1: x = -16'sd1;
          2: y = 16'(h);
          default: y = -16'sd1;
        endcase
      end else begin
        x = 16'($urandom);
        y = 16'($urandom);
      end
      color = $urandom;
      case ($urandom_range(0, 4))
        0: color[7:0] = ALPHA_OPAQUE;
        1: color[7:0] = 8'h00;
        2: color[7:0] = $urandom_range(0, 1) ? 8'h01 : 8'hFE;
        default: ;
      endcase
      send_pixel(x, y, color);
    end
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_px = {out_tuser, out_tdata[15:0], out_tdata[47:16]};
      if (pixel_expect_q.size() == 0) begin
        report_mismatch("unexpected word", 32'h0, {15'h0, got_px.written, got_px.index});
      end else begin
        want_px = pixel_expect_q.pop_front();
        if (got_px.written !== want_px.written)
          report_mismatch("written", 32'(want_px.written), 32'(got_px.written));
        if (got_px.index !== want_px.index)
          report_mismatch("pixel_index", 32'(want_px.index), 32'(got_px.index));
        if (got_px.value !== want_px.value)
          report_mismatch("pixel_value", want_px.value, got_px.value);
      end
      out_stall = out_no_stall ? 0 : $urandom_range(0, 7);
      if (out_stall != 0) begin
        out_tready <= 1'b0;
        stall_left <= out_stall;
      end
    end else if (stall_left != 0) begin
      if (stall_left == 1) out_tready <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!out_tready) begin
      out_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any handshake; covers the clearing sweep
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("alpha_blend_pixel_write_top test failed");
      $finish;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    test_empty_frame();
    test_oversized_frame();

    set_frame_size(1, 1);
    test_random_draws(30, 1'b0);
    set_frame_size(13, 17);
    test_random_draws(70, 1'b0);
    set_frame_size(7, 300);
    out_no_stall = 1'b1;
    test_random_draws(60, 1'b0);
    set_frame_size(511, 2);
    in_no_gap = 1'b1;
    test_random_draws(60, 1'b0);
    in_no_gap = 1'b0;
    out_no_stall = 1'b0;
    set_frame_size(256, 256);
    test_random_draws(100, 1'b1);
    set_frame_size(200, 131);
    test_random_draws(80, 1'b0);

    in_tvalid <= 1'b0;
    while (pixel_expect_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d draws over %0d frame sizes: %0d stored, %0d of them blended",
             draws_sent, sizes_used, pixels_stored, blends_done);
    $display("mismatches seen: %0d", errors);
    if (errors == 0) begin
      $display("alpha_blend_pixel_write_top test passed");
    end else begin
      $display("alpha_blend_pixel_write_top test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/abpw_pkg.sv
rtl/abpw_blend.sv
rtl/alpha_blend_pixel_write_top.sv
tb/tb.sv
